// ===== rtl/core/asn1tlv_pkg.sv =====
// Shared types, status codes and tag tables for the ASN.1 tag-length header parser.
package asn1tlv_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_INNER,
		PH_LEN,
		PH_LENBYTES
	} phase_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK            = 3'd0;
	localparam status_t ST_SHORT_DATA    = 3'd1;
	localparam status_t ST_UNKNOWN_TYPE  = 3'd2;
	localparam status_t ST_BAD_LENGTH    = 3'd3;
	localparam status_t ST_LENGTH_BIG    = 3'd4;
	localparam status_t ST_CTX_MISMATCH  = 3'd5;
	localparam status_t ST_TYPE_MISMATCH = 3'd6;

	localparam logic [1:0] CLASS_UNIVERSAL = 2'b00;
	localparam logic [1:0] CLASS_CONTEXT   = 2'b10;
	localparam logic [7:0] LEN_INVALID     = 8'h7F;
	localparam logic [7:0] LEN_SHORT_MAX   = 8'd126;
	localparam logic [6:0] LEN_LONG_MAX    = 7'd8;
	localparam logic [31:0] BUF_MIN        = 32'd2;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] buf_left;
		logic [3:0]  hdr_cnt;
		logic [3:0]  len_left;
		logic [63:0] len_acc;
		logic [7:0]  held_type;
		logic [7:0]  held_ctx;
		logic [7:0]  exp_ctx;
		logic [7:0]  exp_type;
	} parse_state_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  tag_type;
		logic [7:0]  context_tag;
		logic [3:0]  header_length;
		logic [63:0] content_length;
	} result_t;

	// Universal types the parser recognises.
	function automatic logic known_universal(input logic [7:0] t);
		logic hit;
		case (t) inside
			8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0C,
			8'h13, 8'h16, 8'h17, 8'h18, 8'h30, 8'h31: hit = 1'b1;
			default:                                  hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

// ===== rtl/core/asn1tlv_step.sv =====
// Per-byte decode logic: current parse state and one byte in, next state and result out.
module asn1tlv_step (
	input  asn1tlv_pkg::parse_state_t cur,
	input  logic [7:0]                data_byte,
	input  logic                      start_req,
	input  logic [31:0]               available_bytes,
	input  logic [7:0]                want_context,
	input  logic [7:0]                want_type,
	output asn1tlv_pkg::parse_state_t nxt,
	output logic                      res_valid,
	output asn1tlv_pkg::result_t      res
);

	logic                 emit_now;
	logic                 do_finish;
	asn1tlv_pkg::status_t emit_status;
	asn1tlv_pkg::status_t fin_status;
	asn1tlv_pkg::status_t final_status;
	logic [6:0]           n_bytes;
	logic [32:0]          hdr_ext;
	logic [32:0]          buf_ext;
	logic [31:0]          room;
	logic                 short_room;

	always_comb begin
		nxt         = cur;
		emit_now    = 1'b0;
		do_finish   = 1'b0;
		emit_status = asn1tlv_pkg::ST_OK;
		n_bytes     = data_byte[6:0];
		hdr_ext     = '0;
		buf_ext     = '0;

		if (start_req) begin
			nxt.buf_left  = available_bytes;
			nxt.exp_ctx   = want_context;
			nxt.exp_type  = want_type;
			nxt.hdr_cnt   = 4'd0;
			nxt.len_left  = 4'd0;
			nxt.len_acc   = '0;
			nxt.held_type = 8'd0;
			nxt.held_ctx  = 8'd0;
			buf_ext       = {1'b0, available_bytes};
			if (available_bytes < asn1tlv_pkg::BUF_MIN) begin
				emit_now    = 1'b1;
				emit_status = asn1tlv_pkg::ST_SHORT_DATA;
			end else begin
				nxt.hdr_cnt = 4'd1;
				// Length byte sits at offset one: needs a buffer of at least two.
				hdr_ext     = 33'd2;
				if (data_byte[7:6] == asn1tlv_pkg::CLASS_UNIVERSAL) begin
					if (!asn1tlv_pkg::known_universal(data_byte)) begin
						emit_now    = 1'b1;
						emit_status = asn1tlv_pkg::ST_UNKNOWN_TYPE;
					end else begin
						nxt.held_type = data_byte;
						nxt.phase     = asn1tlv_pkg::PH_LEN;
					end
				end else if (data_byte[7:6] == asn1tlv_pkg::CLASS_CONTEXT) begin
					nxt.held_ctx = data_byte;
					if (data_byte[5]) begin
						nxt.phase = asn1tlv_pkg::PH_INNER;
					end else begin
						nxt.phase = asn1tlv_pkg::PH_LEN;
					end
				end else begin
					nxt.held_type = data_byte;
					nxt.phase     = asn1tlv_pkg::PH_LEN;
				end
			end
		end else begin
			buf_ext = {1'b0, cur.buf_left};
			case (cur.phase)
				asn1tlv_pkg::PH_INNER: begin
					nxt.hdr_cnt = cur.hdr_cnt + 4'd1;
					if (!asn1tlv_pkg::known_universal(data_byte)) begin
						emit_now    = 1'b1;
						emit_status = asn1tlv_pkg::ST_UNKNOWN_TYPE;
					end else begin
						nxt.held_type = data_byte;
						hdr_ext       = {29'd0, nxt.hdr_cnt} + 33'd1;
						if (hdr_ext > buf_ext) begin
							emit_now    = 1'b1;
							emit_status = asn1tlv_pkg::ST_SHORT_DATA;
						end else begin
							nxt.phase = asn1tlv_pkg::PH_LEN;
						end
					end
				end
				asn1tlv_pkg::PH_LEN: begin
					nxt.hdr_cnt = cur.hdr_cnt + 4'd1;
					if (data_byte <= asn1tlv_pkg::LEN_SHORT_MAX) begin
						nxt.len_acc = {56'd0, data_byte};
						do_finish   = 1'b1;
					end else if (data_byte == asn1tlv_pkg::LEN_INVALID
							|| data_byte == {1'b1, asn1tlv_pkg::LEN_INVALID[6:0]}) begin
						emit_now    = 1'b1;
						emit_status = asn1tlv_pkg::ST_BAD_LENGTH;
					end else if (n_bytes > asn1tlv_pkg::LEN_LONG_MAX) begin
						emit_now    = 1'b1;
						emit_status = asn1tlv_pkg::ST_LENGTH_BIG;
					end else begin
						hdr_ext = {29'd0, nxt.hdr_cnt} + {26'd0, n_bytes};
						if (hdr_ext > buf_ext) begin
							emit_now    = 1'b1;
							emit_status = asn1tlv_pkg::ST_SHORT_DATA;
						end else begin
							nxt.len_acc = '0;
							if (n_bytes == 7'd0) begin
								do_finish = 1'b1;
							end else begin
								nxt.len_left = n_bytes[3:0];
								nxt.phase    = asn1tlv_pkg::PH_LENBYTES;
							end
						end
					end
				end
				asn1tlv_pkg::PH_LENBYTES: begin
					nxt.hdr_cnt  = cur.hdr_cnt + 4'd1;
					nxt.len_acc  = {cur.len_acc[55:0], data_byte};
					nxt.len_left = cur.len_left - 4'd1;
					if (nxt.len_left == 4'd0) begin
						do_finish = 1'b1;
					end
				end
				default: begin
					// Idle: drop the byte.
				end
			endcase
		end

		// The start byte checks room for the length byte here as well.
		if (start_req && !emit_now && nxt.phase == asn1tlv_pkg::PH_LEN
				&& hdr_ext > buf_ext) begin
			emit_now    = 1'b1;
			emit_status = asn1tlv_pkg::ST_SHORT_DATA;
		end
	end

	// Final checks once the length is known.
	always_comb begin
		room       = nxt.buf_left - {28'd0, nxt.hdr_cnt};
		short_room = (nxt.buf_left < {28'd0, nxt.hdr_cnt})
			|| ({32'd0, room} < nxt.len_acc);
		if (short_room) begin
			fin_status = asn1tlv_pkg::ST_SHORT_DATA;
		end else if (nxt.exp_ctx != 8'd0 && nxt.held_ctx != nxt.exp_ctx) begin
			fin_status = asn1tlv_pkg::ST_CTX_MISMATCH;
		end else if (nxt.exp_type != 8'd0 && nxt.held_type != nxt.exp_type) begin
			fin_status = asn1tlv_pkg::ST_TYPE_MISMATCH;
		end else begin
			fin_status = asn1tlv_pkg::ST_OK;
		end
	end

	assign final_status = emit_now ? emit_status : fin_status;
	assign res_valid    = emit_now || do_finish;

	always_comb begin
		res        = '0;
		res.status = final_status;
		if (final_status == asn1tlv_pkg::ST_OK) begin
			res.tag_type       = nxt.held_type;
			res.context_tag    = nxt.held_ctx;
			res.header_length  = nxt.hdr_cnt;
			res.content_length = nxt.len_acc;
		end
	end

endmodule

// ===== rtl/core/asn1_tlv_header_parser.sv =====
// Top level of the ASN.1 tag-length header parser: input register, decode, result register.
// A byte taken is held in the input register and decoded from there; its result, if any,
//   is captured in the result register and shows on the result port from there.
// Throughput: one byte per cycle unless a held result stalls, set by the single decode pass.
// A held result stalls decoding only while result_stall is high; one more byte is still taken.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to idle.
module asn1_tlv_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	input  logic [31:0] available_bytes,
	input  logic [7:0]  want_context,
	input  logic [7:0]  want_type,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [7:0]  tag_type,
	output logic [7:0]  context_tag,
	output logic [3:0]  header_length,
	output logic [63:0] content_length
);

	// Input register: one byte with its start sideband.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [31:0] avail_s1;
	logic [7:0]  want_ctx_s1;
	logic [7:0]  want_type_s1;

	// Parse state carried from byte to byte.
	asn1tlv_pkg::parse_state_t state_q;
	asn1tlv_pkg::parse_state_t state_nxt;
	asn1tlv_pkg::parse_state_t state_upd;

	// Result register.
	logic                 res_valid_q;
	asn1tlv_pkg::result_t res_q;

	logic                 step_res_valid;
	asn1tlv_pkg::result_t step_res;
	logic                 advance;
	logic                 in_xfer;

	// Decode the held byte when the result register is free or draining this cycle.
	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign in_xfer    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1      <= data_byte;
			start_s1     <= start_req;
			avail_s1     <= available_bytes;
			want_ctx_s1  <= want_context;
			want_type_s1 <= want_type;
		end
	end

	asn1tlv_step u_step (
		.cur             (state_q),
		.data_byte       (byte_s1),
		.start_req       (start_s1),
		.available_bytes (avail_s1),
		.want_context    (want_ctx_s1),
		.want_type       (want_type_s1),
		.nxt             (state_nxt),
		.res_valid       (step_res_valid),
		.res             (step_res)
	);

	// A result returns the parser to idle.
	always_comb begin
		state_upd = state_nxt;
		if (step_res_valid) begin
			state_upd.phase = asn1tlv_pkg::PH_IDLE;
		end
	end

	// Advance the parse state only on a decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step_res_valid;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res_valid) begin
			res_q <= step_res;
		end
	end

	assign result_valid   = res_valid_q;
	assign status         = res_q.status;
	assign tag_type       = res_q.tag_type;
	assign context_tag    = res_q.context_tag;
	assign header_length  = res_q.header_length;
	assign content_length = res_q.content_length;

endmodule

// ===== dv/asn1_tlv_header_checker.sv =====
// Monitor, header decode predictor and result comparison for the tag-length parser.
`timescale 1ns / 1ps
module asn1_tlv_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	input  logic [31:0] available_bytes,
	input  logic [7:0]  want_context,
	input  logic [7:0]  want_type,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [2:0]  status,
	input  logic [7:0]  tag_type,
	input  logic [7:0]  context_tag,
	input  logic [3:0]  header_length,
	input  logic [63:0] content_length,
	output int          fail_count,
	output int          pending
);

	// Predicted parser state.
	asn1tlv_pkg::phase_t stage;
	logic [31:0] buf_size;
	logic [3:0]  hdr_bytes;
	logic [3:0]  len_bytes_due;
	logic [63:0] len_value;
	logic [7:0]  seen_type;
	logic [7:0]  seen_ctx;
	logic [7:0]  need_ctx;
	logic [7:0]  need_type;

	logic                 decided;
	asn1tlv_pkg::result_t verdict;
	asn1tlv_pkg::result_t header_results[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic recognised_universal(input logic [7:0] t);
		case (t)
			8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0C,
			8'h13, 8'h16, 8'h17, 8'h18, 8'h30, 8'h31: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic close_header(input asn1tlv_pkg::status_t code);
		verdict = '0;
		verdict.status = code;
		if (code == asn1tlv_pkg::ST_OK) begin
			verdict.tag_type = seen_type;
			verdict.context_tag = seen_ctx;
			verdict.header_length = hdr_bytes;
			verdict.content_length = len_value;
		end
		decided = 1'b1;
		stage = asn1tlv_pkg::PH_IDLE;
	endtask

	// Length now known: check that the content fits, then the wanted tags.
	task automatic settle_header();
		logic [63:0] room;
		room = {32'd0, buf_size} - {60'd0, hdr_bytes};
		if ({28'd0, hdr_bytes} > buf_size || room < len_value)
			close_header(asn1tlv_pkg::ST_SHORT_DATA);
		else if (need_ctx != 8'd0 && seen_ctx != need_ctx)
			close_header(asn1tlv_pkg::ST_CTX_MISMATCH);
		else if (need_type != 8'd0 && seen_type != need_type)
			close_header(asn1tlv_pkg::ST_TYPE_MISMATCH);
		else
			close_header(asn1tlv_pkg::ST_OK);
	endtask

	// Tag stage done: the length byte must lie inside the buffer.
	task automatic enter_length();
		if ({60'd0, hdr_bytes} + 64'd1 > {32'd0, buf_size})
			close_header(asn1tlv_pkg::ST_SHORT_DATA);
		else
			stage = asn1tlv_pkg::PH_LEN;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic first, input logic [31:0] avail,
			input logic [7:0] wc, input logic [7:0] wt);
		logic [6:0] long_count;
		decided = 1'b0;
		if (first) begin
			buf_size = avail;
			need_ctx = wc;
			need_type = wt;
			hdr_bytes = 4'd0;
			len_bytes_due = 4'd0;
			len_value = 64'd0;
			seen_type = 8'd0;
			seen_ctx = 8'd0;
			if (avail < asn1tlv_pkg::BUF_MIN) begin
				close_header(asn1tlv_pkg::ST_SHORT_DATA);
			end else begin
				hdr_bytes = 4'd1;
				if (b[7:6] == asn1tlv_pkg::CLASS_UNIVERSAL) begin
					if (!recognised_universal(b)) begin
						close_header(asn1tlv_pkg::ST_UNKNOWN_TYPE);
					end else begin
						seen_type = b;
						enter_length();
					end
				end else if (b[7:6] == asn1tlv_pkg::CLASS_CONTEXT) begin
					seen_ctx = b;
					if (b[5])
						stage = asn1tlv_pkg::PH_INNER;
					else
						enter_length();
				end else begin
					seen_type = b;
					enter_length();
				end
			end
		end else begin
			case (stage)
				asn1tlv_pkg::PH_INNER: begin
					hdr_bytes++;
					if (!recognised_universal(b)) begin
						close_header(asn1tlv_pkg::ST_UNKNOWN_TYPE);
					end else begin
						seen_type = b;
						enter_length();
					end
				end
				asn1tlv_pkg::PH_LEN: begin
					hdr_bytes++;
					long_count = b[6:0];
					if (b <= asn1tlv_pkg::LEN_SHORT_MAX) begin
						len_value = {56'd0, b};
						settle_header();
					end else if (long_count == asn1tlv_pkg::LEN_INVALID[6:0]) begin
						close_header(asn1tlv_pkg::ST_BAD_LENGTH);
					end else if (long_count > asn1tlv_pkg::LEN_LONG_MAX) begin
						close_header(asn1tlv_pkg::ST_LENGTH_BIG);
					end else if ({60'd0, hdr_bytes} + {57'd0, long_count} > {32'd0, buf_size}) begin
						close_header(asn1tlv_pkg::ST_SHORT_DATA);
					end else begin
						len_value = 64'd0;
						if (long_count == 7'd0) begin
							settle_header();
						end else begin
							len_bytes_due = long_count[3:0];
							stage = asn1tlv_pkg::PH_LENBYTES;
						end
					end
				end
				asn1tlv_pkg::PH_LENBYTES: begin
					hdr_bytes++;
					len_value = {len_value[55:0], b};
					len_bytes_due--;
					if (len_bytes_due == 4'd0)
						settle_header();
				end
				default: ;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		asn1tlv_pkg::result_t want;
		if (!arst_n) begin
			stage = asn1tlv_pkg::PH_IDLE;
			buf_size = '0;
			hdr_bytes = '0;
			len_bytes_due = '0;
			len_value = '0;
			seen_type = '0;
			seen_ctx = '0;
			need_ctx = '0;
			need_type = '0;
			decided = 1'b0;
			header_results.delete();
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (header_results.size() == 0) begin
					report_mismatch($sformatf("result with none outstanding, status %0d", status));
				end else begin
					want = header_results.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status: got %0h, expected %0h",
							status, want.status));
					if (tag_type !== want.tag_type)
						report_mismatch($sformatf("tag_type: got %0h, expected %0h",
							tag_type, want.tag_type));
					if (context_tag !== want.context_tag)
						report_mismatch($sformatf("context_tag: got %0h, expected %0h",
							context_tag, want.context_tag));
					if (header_length !== want.header_length)
						report_mismatch($sformatf("header_length: got %0h, expected %0h",
							header_length, want.header_length));
					if (content_length !== want.content_length)
						report_mismatch($sformatf("content_length: got %0h, expected %0h",
							content_length, want.content_length));
				end
			end
			if (item_valid && !item_stall) begin
				decode_byte(data_byte, start_req, available_bytes, want_context, want_type);
				if (decided)
					header_results.push_back(verdict);
			end
			pending = header_results.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the tag-length parser testbench: clock, reset, byte stimulus, result stalls, verdict.
`timescale 1ns / 1ps
module testbench;

	localparam int BYTE_TARGET    = 1350;
	// No transfer on either channel for this long means the parser has hung.
	localparam int WATCHDOG_LIMIT = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        start_req = 1'b0;
	logic [31:0] available_bytes = 32'd0;
	logic [7:0]  want_context = 8'd0;
	logic [7:0]  want_type = 8'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  tag_type;
	logic [7:0]  context_tag;
	logic [3:0]  header_length;
	logic [63:0] content_length;

	int          mismatch_total;
	int          results_outstanding;
	int          quiet_cycles = 0;
	// High during a stretch where neither side idles nor stalls.
	logic        calm = 1'b0;

	always #2 clk = ~clk;

	asn1_tlv_header_parser DUT (.*);

	asn1_tlv_header_checker header_checker (
		.*,
		.fail_count(mismatch_total),
		.pending(results_outstanding)
	);

	// Stall the result side in about one cycle out of seven, except in the calm stretch.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 14);
	end

	// Count cycles without any transfer; give up once the limit is reached.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] pick_known_type();
		case ($urandom_range(0, 11))
			0: return 8'h02;
			1: return 8'h03;
			2: return 8'h04;
			3: return 8'h05;
			4: return 8'h06;
			5: return 8'h0C;
			6: return 8'h13;
			7: return 8'h16;
			8: return 8'h17;
			9: return 8'h18;
			10: return 8'h30;
			default: return 8'h31;
		endcase
	endfunction

	// Offer one byte and hold it until the parser takes it; idle first now and then.
	task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] avail,
			input logic [7:0] wc, input logic [7:0] wt);
		while (!calm && $urandom_range(0, 99) < 14) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= b;
		start_req <= first;
		available_bytes <= avail;
		want_context <= wc;
		want_type <= wt;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Build one header with random content, mostly well formed, and send it.
	task automatic send_header(output int count);
		logic [7:0]  hdr_bytes[$];
		logic [7:0]  tag;
		logic [7:0]  inner;
		logic [7:0]  type_seen;
		logic [63:0] content;
		logic [63:0] total;
		logic [31:0] avail;
		logic [7:0]  wc;
		logic [7:0]  wt;
		int          n;
		int          pick;
		int          keep;
		inner = 8'h00;
		content = 64'd0;

		// Tag: mostly known universal types, then context, application and private.
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			tag = pick_known_type();
		end else if (pick < 55) begin
			tag = 8'($urandom_range(0, 63));
		end else if (pick < 70) begin
			tag = 8'h80 | 8'($urandom_range(0, 31));
		end else if (pick < 88) begin
			tag = 8'hA0 | 8'($urandom_range(0, 31));
			inner = ($urandom_range(0, 99) < 85) ? pick_known_type()
				: 8'($urandom_range(0, 255));
		end else begin
			tag = 8'($urandom_range(0, 255));
			tag[6] = 1'b1;
		end
		hdr_bytes.push_back(tag);
		if (tag[7:5] == 3'b101)
			hdr_bytes.push_back(inner);

		// Length: short form, long form up to eight bytes, invalid, or oversized count.
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			content = 64'($urandom_range(0, 126));
			hdr_bytes.push_back(content[7:0]);
		end else if (pick < 85) begin
			n = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0)
				content = {$urandom, $urandom};
			else
				content = 64'($urandom_range(0, 600));
			if (n < 8)
				content = content & ((64'd1 << (8 * n)) - 64'd1);
			hdr_bytes.push_back(8'h80 | 8'(n));
			for (int i = n - 1; i >= 0; i--)
				hdr_bytes.push_back(content[8 * i +: 8]);
		end else if (pick < 92) begin
			hdr_bytes.push_back($urandom_range(0, 1) ? 8'hFF : 8'h7F);
		end else begin
			hdr_bytes.push_back(8'h80 | 8'($urandom_range(9, 126)));
		end

		// Buffer size: usually just enough, sometimes one short, sometimes anything.
		total = 64'(hdr_bytes.size()) + content;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			total = total + 64'($urandom_range(0, 3));
			avail = (total > 64'hFFFF_FFFF) ? $urandom : total[31:0];
		end else if (pick < 80) begin
			avail = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0] - 32'd1;
		end else if (pick < 88) begin
			avail = $urandom_range(0, 4);
		end else if (pick < 95) begin
			avail = $urandom;
		end else begin
			avail = 32'hFFFF_FFFF;
		end

		// Wanted tags: mostly any, often the right one, sometimes random.
		type_seen = (tag[7:5] == 3'b101) ? inner : (tag[7:6] == 2'b10) ? 8'h00 : tag;
		pick = $urandom_range(0, 99);
		wc = (pick < 75) ? 8'h00 : (pick < 88) ? tag : 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		wt = (pick < 75) ? 8'h00 : (pick < 88) ? type_seen : 8'($urandom_range(0, 255));

		// Cut a header short now and then so that the next start abandons it.
		keep = hdr_bytes.size();
		if ($urandom_range(0, 99) < 8)
			keep = $urandom_range(1, hdr_bytes.size() - 1);

		send_byte(hdr_bytes[0], 1'b1, avail, wc, wt);
		for (int i = 1; i < keep; i++)
			send_byte(hdr_bytes[i], 1'b0, $urandom, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		count = keep;
	endtask

	initial begin
		int sent;
		int burst;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed headers first.
		// Tiny buffer: refused at the start byte.
		send_byte(8'h02, 1'b1, 32'd0, 8'h00, 8'h00);
		// Idle byte after a result: ignored.
		send_byte(8'h30, 1'b0, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		// Plain INTEGER, short form, fits exactly.
		send_byte(8'h02, 1'b1, 32'd7, 8'h00, 8'h00);
		send_byte(8'h05, 1'b0, 32'd0, 8'h00, 8'h00);
		// Long form with no length bytes.
		send_byte(8'h04, 1'b1, 32'd2, 8'h00, 8'h00);
		send_byte(8'h80, 1'b0, 32'd0, 8'h00, 8'h00);
		// Invalid length bytes, both forms.
		send_byte(8'h30, 1'b1, 32'd100, 8'h00, 8'h00);
		send_byte(8'h7F, 1'b0, 32'd0, 8'h00, 8'h00);
		send_byte(8'h31, 1'b1, 32'd100, 8'h00, 8'h00);
		send_byte(8'hFF, 1'b0, 32'd0, 8'h00, 8'h00);
		// Long form with more than eight length bytes.
		send_byte(8'h04, 1'b1, 32'd100, 8'h00, 8'h00);
		send_byte(8'h89, 1'b0, 32'd0, 8'h00, 8'h00);
		// Long form running past the end of the buffer.
		send_byte(8'h04, 1'b1, 32'd3, 8'h00, 8'h00);
		send_byte(8'h82, 1'b0, 32'd0, 8'h00, 8'h00);
		// Content running past the end of the buffer.
		send_byte(8'h05, 1'b1, 32'd10, 8'h00, 8'h00);
		send_byte(8'h7E, 1'b0, 32'd0, 8'h00, 8'h00);
		// Unknown universal type.
		send_byte(8'h01, 1'b1, 32'd50, 8'h00, 8'h00);
		// Constructed context tag with no room left for the length byte.
		send_byte(8'hA0, 1'b1, 32'd2, 8'h00, 8'h00);
		send_byte(8'h30, 1'b0, 32'd0, 8'h00, 8'h00);
		// Restart in the middle of a header: the first one is dropped silently.
		send_byte(8'h0C, 1'b1, 32'd40, 8'h00, 8'h00);
		send_byte(8'h16, 1'b1, 32'd3, 8'h00, 8'h00);
		send_byte(8'h01, 1'b0, 32'd0, 8'h00, 8'h00);
		// Context and type mismatches.
		send_byte(8'h81, 1'b1, 32'd2, 8'h82, 8'h00);
		send_byte(8'h00, 1'b0, 32'd0, 8'h00, 8'h00);
		send_byte(8'h13, 1'b1, 32'd2, 8'h00, 8'h16);
		send_byte(8'h00, 1'b0, 32'd0, 8'h00, 8'h00);

		// Random headers, with a stretch in the middle where nobody idles or stalls.
		while (sent < BYTE_TARGET) begin
			calm <= (sent >= 500 && sent < 750);
			send_header(burst);
			sent += burst;
			if ($urandom_range(0, 99) < 6) begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom,
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		end

		// Drain: let the last transfer reach the checker, then wait for outstanding results.
		item_valid <= 1'b0;
		@(posedge clk);
		wait (results_outstanding == 0);
		repeat (8) @(posedge clk);
		if (mismatch_total == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
